FILE: src/tmse_pkg.sv
package tmse_pkg;

    // Input field width
    localparam int DIM_BITS = 16;

    // Working width for sizes: input fields and the 16-bit minimum registers
    localparam int XW  = (DIM_BITS > 16) ? DIM_BITS : 16;
    localparam int XW1 = XW + 1;
    // Width of a halving count (0 .. XW)
    localparam int CW  = $clog2(XW + 1);
    // Step index of the serial divider
    localparam int KW  = $clog2(XW);

    localparam int CFG_W    = 16;
    localparam int FIT_W    = 17;
    localparam int BYTES_W  = 36;
    localparam int MIP_W    = 5;

    localparam logic [FIT_W-1:0]   FIT_MAX   = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [MIP_W-1:0]   MIP_MAX   = '1;

    // Register indexes
    localparam logic [3:0] REG_MIN_WIDTH   = 4'd0;
    localparam logic [3:0] REG_MIN_HEIGHT  = 4'd1;
    localparam logic [3:0] REG_BLOCK_WIDTH = 4'd2;
    localparam logic [3:0] REG_BLOCK_HEIGHT = 4'd3;
    localparam logic [3:0] REG_BITS_PER_BLOCK = 4'd4;
    localparam logic [3:0] REG_IS_COMPRESSED  = 4'd5;
    localparam logic [3:0] REG_NEEDS_SQUARE   = 4'd6;
    localparam logic [3:0] REG_IGNORE_BLOCK   = 4'd7;

    // Register reset values
    localparam logic [15:0] RST_MIN_WIDTH      = 16'd1;
    localparam logic [15:0] RST_MIN_HEIGHT     = 16'd1;
    localparam logic [3:0]  RST_BLOCK_WIDTH    = 4'd1;
    localparam logic [3:0]  RST_BLOCK_HEIGHT   = 4'd1;
    localparam logic [7:0]  RST_BITS_PER_BLOCK = 8'd32;

    // Command to the serial divide / halving unit
    typedef struct packed {
        logic          start;
        logic [XW-1:0] dividend;
        logic [3:0]    divisor;
        logic [XW-1:0] lim;
        logic          ign;
    } t_div_ctl;

    // Result of one pass
    typedef struct packed {
        logic          done;
        logic [XW-1:0] quo;
        logic [3:0]    rem;
        logic [CW-1:0] cnt;
    } t_div_res;

    function automatic logic is_pow2_or_zero(input logic [XW-1:0] v);
        return (v & (v - XW'(1))) == '0;
    endfunction

    // Smallest power of two >= v, v >= 1
    function automatic logic [XW:0] pow2_ceil(input logic [XW-1:0] v);
        logic [XW-1:0] s;
        s = v - XW'(1);
        for (int i = 1; i < XW; i = i * 2) begin
            s = s | (s >> i);
        end
        return {1'b0, s} + XW1'(1);
    endfunction

endpackage

FILE: src/tmse_div_unit.sv
// Serial MSB-first divide by a 4-bit divisor, one dividend bit per cycle.
// The running prefix equals dividend >> k, so the halving test
// (prefix >= lim and, unless ign is set, prefix % divisor == 0) is checked on the way down;
// the count of passing steps, reset on a failure, ends as the halving count.
module tmse_div_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmse_pkg::t_div_ctl i_ctl,
    output tmse_pkg::t_div_res o_res
);

    logic                        r_busy;
    logic                        r_done;
    logic [tmse_pkg::KW-1:0]     r_k;
    logic [tmse_pkg::XW-1:0]     r_sh;
    logic [tmse_pkg::XW-1:0]     r_pref;
    logic [tmse_pkg::XW-1:0]     r_q;
    logic [3:0]                  r_rem;
    logic [tmse_pkg::CW-1:0]     r_cnt;
    logic [3:0]                  r_div;
    logic [tmse_pkg::XW-1:0]     r_lim;
    logic                        r_ign;

    logic                        s_bit;
    logic [tmse_pkg::XW-1:0]     n_pref;
    logic [4:0]                  s_part;
    logic                        s_ge;
    logic [3:0]                  n_rem;
    logic                        s_ok;
    logic [tmse_pkg::CW-1:0]     n_cnt;

    always_comb begin
        s_bit  = r_sh[tmse_pkg::XW-1];
        n_pref = {r_pref[tmse_pkg::XW-2:0], s_bit};
        s_part = {r_rem, s_bit};
        s_ge   = s_part >= {1'b0, r_div};
        n_rem  = s_ge ? 4'(s_part - {1'b0, r_div}) : s_part[3:0];
        s_ok   = (n_pref >= r_lim) && (r_ign || (n_rem == 4'd0));
        n_cnt  = s_ok ? (r_cnt + tmse_pkg::CW'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_k    <= tmse_pkg::KW'(tmse_pkg::XW - 1);
                r_sh   <= i_ctl.dividend;
                r_pref <= '0;
                r_q    <= '0;
                r_rem  <= 4'd0;
                r_cnt  <= '0;
                r_div  <= i_ctl.divisor;
                r_lim  <= i_ctl.lim;
                r_ign  <= i_ctl.ign;
            end else if (r_busy) begin
                r_sh   <= {r_sh[tmse_pkg::XW-2:0], 1'b0};
                r_pref <= n_pref;
                r_q    <= {r_q[tmse_pkg::XW-2:0], s_ge};
                r_rem  <= n_rem;
                r_cnt  <= n_cnt;
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - tmse_pkg::KW'(1);
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_q;
    assign o_res.rem  = r_rem;
    assign o_res.cnt  = r_cnt;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_ctl.start && (r_k == '0) |=> r_done && !r_busy)
        else $error("divider did not finish after last step");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && (r_div != 4'd0) |-> r_rem < r_div)
        else $error("remainder not below divisor");

endmodule

FILE: src/texture_mip_and_size_evaluator.sv
// Texture mip count and size evaluator.
//
// Input channel (i_in_valid / o_in_ready) takes one word: image width,
// height and depth. Output channel (o_out_valid / i_out_ready) gives one
// word per input: mip count, size-valid flag, fitted width and height, and
// the byte size of the image, saturated (zero when the size is not legal).
// The format is described by eight registers on the plain write port
// (i_cfg_we, i_cfg_index, i_cfg_data); write them only while idle.
//
// One serial divider does all the work, one bit per cycle: a width pass
// and a height pass (quotient, remainder and halving count together; the
// depth count runs alongside the width pass), and for block-rounded
// formats one extra pass per side that sits below its minimum. Then the
// states S_MUL1 and S_MUL2 do the two multiplies and S_DONE loads the
// output register, and the next word is accepted in the cycle the result
// shows.
// Reset returns the registers to their defaults and empties the block.
// A result not yet taken sits in the output register; a new word is still
// taken meanwhile, and the block then holds its next result internally
// until the output register frees up.
module texture_mip_and_size_evaluator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tmse_pkg::DIM_BITS-1:0] i_image_width,
    input  logic [tmse_pkg::DIM_BITS-1:0] i_image_height,
    input  logic [tmse_pkg::DIM_BITS-1:0] i_image_depth,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tmse_pkg::MIP_W-1:0]    o_mip_count,
    output logic                          o_size_valid,
    output logic [tmse_pkg::FIT_W-1:0]    o_fit_width,
    output logic [tmse_pkg::FIT_W-1:0]    o_fit_height,
    output logic [tmse_pkg::BYTES_W-1:0]  o_data_bytes,

    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_index,
    input  logic [tmse_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int XW  = tmse_pkg::XW;
    localparam int CW  = tmse_pkg::CW;
    localparam int FX  = XW + 2;                 // fit arithmetic width
    localparam int BW2 = 2 * XW;                 // block count width
    localparam int PW  = BW2 + 8;                // blocks * bits_per_block
    localparam int MCW = (CW > tmse_pkg::MIP_W) ? CW : tmse_pkg::MIP_W;
    localparam logic [63:0] BLK_LIMIT = 64'd1 << 39;

    typedef enum logic [2:0] {S_IDLE, S_PASS, S_MUL1, S_MUL2, S_DONE} t_state;
    typedef enum logic [1:0] {P_W, P_H, P_FW, P_FH} t_pass;

    // Format registers
    logic [15:0] r_min_width, r_min_height;
    logic [3:0]  r_block_width, r_block_height;
    logic [7:0]  r_bits_per_block;
    logic        r_is_compressed, r_needs_square, r_ignore_block;

    t_state r_state, n_state;
    t_pass  r_pass, n_pass;

    // Word under work
    logic [XW-1:0]  r_w, r_h, r_dsh;
    logic           r_dseen;
    logic [CW-1:0]  r_cd, r_cw, r_ch;
    logic [XW-1:0]  r_qw, r_qh;
    logic [3:0]     r_rw, r_rh, r_rfw, r_rfh;
    logic [tmse_pkg::MIP_W-1:0] r_mips;
    logic           r_valid;
    logic [tmse_pkg::FIT_W-1:0] r_fw, r_fh;
    logic [BW2-1:0] r_blocks;
    logic [PW-1:0]  r_prod;

    // Output register
    logic           r_ovalid;
    logic [tmse_pkg::MIP_W-1:0]   r_omips;
    logic           r_ovalid_size;
    logic [tmse_pkg::FIT_W-1:0]   r_ofw, r_ofh;
    logic [tmse_pkg::BYTES_W-1:0] r_obytes;

    tmse_pkg::t_div_ctl s_ctl;
    tmse_pkg::t_div_res s_res;

    // Effective format values
    logic [XW-1:0] s_mw, s_mh;
    logic [3:0]    s_bw, s_bh;
    logic          s_ign, s_sq, s_round, s_need_fw, s_need_fh, s_launch;
    logic          s_load;

    always_comb begin
        s_mw      = (r_min_width == 16'd0) ? XW'(1) : XW'(r_min_width);
        s_mh      = (r_min_height == 16'd0) ? XW'(1) : XW'(r_min_height);
        s_bw      = (r_block_width == 4'd0) ? 4'd1 : r_block_width;
        s_bh      = (r_block_height == 4'd0) ? 4'd1 : r_block_height;
        s_ign     = r_ignore_block;
        s_sq      = r_needs_square;
        s_round   = !s_ign && !s_sq;
        s_need_fw = s_round && (r_w < s_mw);
        s_need_fh = s_round && (r_h < s_mh);
    end

    assign s_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    // Sequencer: picks the next divider pass and launches it
    always_comb begin
        n_state  = r_state;
        n_pass   = r_pass;
        s_launch = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pass   = P_W;
                    s_launch = 1'b1;
                    n_state  = S_PASS;
                end
            end
            S_PASS: begin
                if (s_res.done) begin
                    case (r_pass)
                        P_W: begin
                            n_pass   = P_H;
                            s_launch = 1'b1;
                        end
                        P_H: begin
                            if (s_need_fw) begin
                                n_pass   = P_FW;
                                s_launch = 1'b1;
                            end else if (s_need_fh) begin
                                n_pass   = P_FH;
                                s_launch = 1'b1;
                            end else begin
                                n_state = S_MUL1;
                            end
                        end
                        P_FW: begin
                            if (s_need_fh) begin
                                n_pass   = P_FH;
                                s_launch = 1'b1;
                            end else begin
                                n_state = S_MUL1;
                            end
                        end
                        default: n_state = S_MUL1;
                    endcase
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_DONE;
            S_DONE: begin
                if (s_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        s_ctl.start = s_launch;
        s_ctl.ign   = s_ign;
        case (n_pass)
            P_W: begin
                s_ctl.dividend = XW'(i_image_width);
                s_ctl.divisor  = s_bw;
                s_ctl.lim      = s_mw;
            end
            P_H: begin
                s_ctl.dividend = r_h;
                s_ctl.divisor  = s_bh;
                s_ctl.lim      = s_mh;
            end
            P_FW: begin
                s_ctl.dividend = s_mw;
                s_ctl.divisor  = s_bw;
                s_ctl.lim      = s_mw;
            end
            default: begin
                s_ctl.dividend = s_mh;
                s_ctl.divisor  = s_bh;
                s_ctl.lim      = s_mh;
            end
        endcase
    end

    tmse_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .o_res   (s_res)
    );

    // Depth lane: bit length of depth, one bit per width-pass cycle
    logic s_dseen;
    assign s_dseen = r_dseen | r_dsh[XW-1];

    // Result assembly (MUL1 stage)
    logic [CW-1:0]  s_mips_raw, s_cmax;
    logic [MCW-1:0] s_mips_ext;
    logic           s_valid;
    logic [XW-1:0]  s_fw0, s_fh0, s_mx;
    logic [XW:0]    s_p2;
    logic           s_sq_fix;
    logic [3:0]     s_rem_fw, s_rem_fh;
    logic [FX-1:0]  s_fw1, s_fh1, s_upw, s_uph;
    logic [XW-1:0]  s_ceil_w, s_ceil_h;

    always_comb begin
        s_cmax     = (r_cw > r_ch) ? r_cw : r_ch;
        if (r_is_compressed) begin
            s_mips_raw = (r_cw < r_ch) ? r_cw : r_ch;
        end else begin
            s_mips_raw = (r_cd > s_cmax) ? r_cd : s_cmax;
        end
        if (s_mips_raw == '0) s_mips_raw = CW'(1);
        s_mips_ext = MCW'(s_mips_raw);
        if (s_mips_ext > MCW'(tmse_pkg::MIP_MAX)) s_mips_ext = MCW'(tmse_pkg::MIP_MAX);

        // Legal size: square rule, then minimum, then block multiple
        if (s_sq && ((r_w != r_h) || !tmse_pkg::is_pow2_or_zero(r_w))) begin
            s_valid = 1'b0;
        end else if ((r_w < s_mw) || (r_h < s_mh)) begin
            s_valid = 1'b0;
        end else if (!s_ign && ((r_rw != 4'd0) || (r_rh != 4'd0))) begin
            s_valid = 1'b0;
        end else begin
            s_valid = 1'b1;
        end

        // Fitted size
        s_fw0    = (r_w < s_mw) ? s_mw : r_w;
        s_fh0    = (r_h < s_mh) ? s_mh : r_h;
        s_mx     = (s_fw0 > s_fh0) ? s_fw0 : s_fh0;
        s_p2     = tmse_pkg::pow2_ceil(s_mx);
        s_sq_fix = s_sq && ((s_fw0 != s_fh0) || !tmse_pkg::is_pow2_or_zero(s_fw0));
        s_rem_fw = (r_w < s_mw) ? r_rfw : r_rw;
        s_rem_fh = (r_h < s_mh) ? r_rfh : r_rh;
        s_upw    = FX'(s_fw0) + ((s_rem_fw != 4'd0) ? FX'(s_bw - s_rem_fw) : FX'(0));
        s_uph    = FX'(s_fh0) + ((s_rem_fh != 4'd0) ? FX'(s_bh - s_rem_fh) : FX'(0));
        if (s_sq_fix) begin
            s_fw1 = FX'(s_p2);
            s_fh1 = FX'(s_p2);
        end else if (s_round) begin
            s_fw1 = s_upw;
            s_fh1 = s_uph;
        end else begin
            s_fw1 = FX'(s_fw0);
            s_fh1 = FX'(s_fh0);
        end

        // Block counts, rounded up
        s_ceil_w = r_qw + ((r_rw != 4'd0) ? XW'(1) : XW'(0));
        s_ceil_h = r_qh + ((r_rh != 4'd0) ? XW'(1) : XW'(0));
    end

    // Byte size, saturated
    logic [PW-1:0]                s_bytes_full;
    logic [tmse_pkg::BYTES_W-1:0] s_bytes;
    always_comb begin
        s_bytes_full = r_prod >> 3;
        if (!r_valid) begin
            s_bytes = '0;
        end else if ((64'(r_blocks) > BLK_LIMIT) ||
                     (s_bytes_full > PW'(tmse_pkg::BYTES_MAX))) begin
            s_bytes = tmse_pkg::BYTES_MAX;
        end else begin
            s_bytes = s_bytes_full[tmse_pkg::BYTES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_pass           <= P_W;
            r_ovalid         <= 1'b0;
            r_min_width      <= tmse_pkg::RST_MIN_WIDTH;
            r_min_height     <= tmse_pkg::RST_MIN_HEIGHT;
            r_block_width    <= tmse_pkg::RST_BLOCK_WIDTH;
            r_block_height   <= tmse_pkg::RST_BLOCK_HEIGHT;
            r_bits_per_block <= tmse_pkg::RST_BITS_PER_BLOCK;
            r_is_compressed  <= 1'b0;
            r_needs_square   <= 1'b0;
            r_ignore_block   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    tmse_pkg::REG_MIN_WIDTH:      r_min_width      <= i_cfg_data[15:0];
                    tmse_pkg::REG_MIN_HEIGHT:     r_min_height     <= i_cfg_data[15:0];
                    tmse_pkg::REG_BLOCK_WIDTH:    r_block_width    <= i_cfg_data[3:0];
                    tmse_pkg::REG_BLOCK_HEIGHT:   r_block_height   <= i_cfg_data[3:0];
                    tmse_pkg::REG_BITS_PER_BLOCK: r_bits_per_block <= i_cfg_data[7:0];
                    tmse_pkg::REG_IS_COMPRESSED:  r_is_compressed  <= i_cfg_data[0];
                    tmse_pkg::REG_NEEDS_SQUARE:   r_needs_square   <= i_cfg_data[0];
                    tmse_pkg::REG_IGNORE_BLOCK:   r_ignore_block   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // Latch the word
            if ((r_state == S_IDLE) && i_in_valid) begin
                r_w     <= XW'(i_image_width);
                r_h     <= XW'(i_image_height);
                r_dsh   <= XW'(i_image_depth);
                r_dseen <= 1'b0;
                r_cd    <= '0;
            end

            // Depth lane steps with the width pass
            if ((r_state == S_PASS) && (r_pass == P_W) && !s_res.done) begin
                r_dsh   <= {r_dsh[XW-2:0], 1'b0};
                r_dseen <= s_dseen;
                if (s_dseen) r_cd <= r_cd + CW'(1);
            end

            if ((r_state == S_PASS) && s_res.done) begin
                case (r_pass)
                    P_W: begin
                        r_qw <= s_res.quo;
                        r_rw <= s_res.rem;
                        r_cw <= s_res.cnt;
                    end
                    P_H: begin
                        r_qh <= s_res.quo;
                        r_rh <= s_res.rem;
                        r_ch <= s_res.cnt;
                    end
                    P_FW:    r_rfw <= s_res.rem;
                    default: r_rfh <= s_res.rem;
                endcase
            end

            if (r_state == S_MUL1) begin
                r_mips   <= s_mips_ext[tmse_pkg::MIP_W-1:0];
                r_valid  <= s_valid;
                r_fw     <= (s_fw1 > FX'(tmse_pkg::FIT_MAX)) ? tmse_pkg::FIT_MAX
                                                              : s_fw1[tmse_pkg::FIT_W-1:0];
                r_fh     <= (s_fh1 > FX'(tmse_pkg::FIT_MAX)) ? tmse_pkg::FIT_MAX
                                                              : s_fh1[tmse_pkg::FIT_W-1:0];
                r_blocks <= BW2'(s_ceil_w) * BW2'(s_ceil_h);
            end

            if (r_state == S_MUL2) begin
                r_prod <= PW'(r_blocks) * PW'(r_bits_per_block);
            end

            if (s_load) begin
                r_ovalid      <= 1'b1;
                r_omips       <= r_mips;
                r_ovalid_size <= r_valid;
                r_ofw         <= r_fw;
                r_ofh         <= r_fh;
                r_obytes      <= s_bytes;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_mip_count  = r_omips;
    assign o_size_valid = r_ovalid_size;
    assign o_fit_width  = r_ofw;
    assign o_fit_height = r_ofh;
    assign o_data_bytes = r_obytes;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accepting a word");

    a_mips_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_mip_count != '0)
        else $error("mip count of zero delivered");

    a_bytes_zero_if_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_size_valid |-> o_data_bytes == '0)
        else $error("nonzero byte size on an illegal size");

    a_done_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res.done |-> r_state == S_PASS)
        else $error("divider finished outside a pass");

endmodule

FILE: tb/sv/tb.sv
module tb;

    // The drain wait sits above the worst accept-to-result latency.
    localparam int DRAIN_CYCLES     = 80;
    // Longest quiet stretch in a correct run is the drain, the config writes
    // and one full latency together; this is well clear of it.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_FORMATS   = 9;
    localparam int WORDS_PER_FORMAT = 58;

    // One expected output word
    typedef struct packed {
        logic [tmse_pkg::MIP_W-1:0]   mips;
        logic                         ok;
        logic [tmse_pkg::FIT_W-1:0]   fit_w;
        logic [tmse_pkg::FIT_W-1:0]   fit_h;
        logic [tmse_pkg::BYTES_W-1:0] nbytes;
    } t_size_answer;

    // Receiver stall styles
    typedef enum int unsigned {RX_OPEN, RX_COIN, RX_LONG} t_rx_mode;

    // Format registers mirrored on the write side, plus the queue of words
    // still owed by the block.
    class t_mip_size_scoreboard;
        logic [15:0]  min_w, min_h;
        logic [3:0]   blk_w, blk_h;
        logic [7:0]   bits_per_blk;
        logic         compressed, square_pow2, ignore_blk;
        t_size_answer pending_answers[$];
        int unsigned  n_checked, n_bad;

        function new();
            min_w        = tmse_pkg::RST_MIN_WIDTH;
            min_h        = tmse_pkg::RST_MIN_HEIGHT;
            blk_w        = tmse_pkg::RST_BLOCK_WIDTH;
            blk_h        = tmse_pkg::RST_BLOCK_HEIGHT;
            bits_per_blk = tmse_pkg::RST_BITS_PER_BLOCK;
            compressed   = 1'b0;
            square_pow2  = 1'b0;
            ignore_blk   = 1'b0;
            n_checked    = 0;
            n_bad        = 0;
        endfunction

        function void set_reg(logic [3:0] idx, logic [tmse_pkg::CFG_W-1:0] data);
            case (idx)
                tmse_pkg::REG_MIN_WIDTH:      min_w = data[15:0];
                tmse_pkg::REG_MIN_HEIGHT:     min_h = data[15:0];
                tmse_pkg::REG_BLOCK_WIDTH:    blk_w = data[3:0];
                tmse_pkg::REG_BLOCK_HEIGHT:   blk_h = data[3:0];
                tmse_pkg::REG_BITS_PER_BLOCK: bits_per_blk = data[7:0];
                tmse_pkg::REG_IS_COMPRESSED:  compressed = data[0];
                tmse_pkg::REG_NEEDS_SQUARE:   square_pow2 = data[0];
                tmse_pkg::REG_IGNORE_BLOCK:   ignore_blk = data[0];
                default: ;  // out-of-range index: no effect
            endcase
        endfunction

        // Number of halvings while t stays >= mn and, unless ign, a multiple of blk
        function longint unsigned halvings(longint unsigned t, longint unsigned mn,
                                           longint unsigned blk, bit ign);
            longint unsigned n;
            n = 0;
            while (t >= mn && (ign || t % blk == 0)) begin
                n++;
                t >>= 1;
            end
            return n;
        endfunction

        function t_size_answer predict_sizes(logic [tmse_pkg::DIM_BITS-1:0] iw, ih, id);
            longint unsigned w, h, d, mw, mh, bw, bh;
            longint unsigned cw, ch, cd, mips, fw, fh, side, p, blocks, nbytes;
            bit ok;
            t_size_answer a;
            w  = iw;
            h  = ih;
            d  = id;
            // zero minimum / zero block act as 1
            mw = (min_w == 0) ? 1 : min_w;
            mh = (min_h == 0) ? 1 : min_h;
            bw = (blk_w == 0) ? 1 : blk_w;
            bh = (blk_h == 0) ? 1 : blk_h;

            cw = halvings(w, mw, bw, ignore_blk);
            ch = halvings(h, mh, bh, ignore_blk);
            cd = halvings(d, 1, 1, 1'b1);
            if (compressed) begin
                mips = (cw < ch) ? cw : ch;
            end else begin
                mips = (cw > ch) ? cw : ch;
                if (cd > mips) mips = cd;
            end
            if (mips < 1) mips = 1;
            if (mips > tmse_pkg::MIP_MAX) mips = tmse_pkg::MIP_MAX;

            // zero counts as a power of two; the minimum rule still rejects it
            ok = 1'b1;
            if (square_pow2 && (w != h || (w & (w - 1)) != 0)) ok = 1'b0;
            else if (w < mw || h < mh) ok = 1'b0;
            else if (!ignore_blk && (w % bw != 0 || h % bh != 0)) ok = 1'b0;

            fw = (w < mw) ? mw : w;
            fh = (h < mh) ? mh : h;
            if (square_pow2 && (fw != fh || (fw & (fw - 1)) != 0)) begin
                side = (fw > fh) ? fw : fh;
                p = 1;
                while (p < side) p <<= 1;
                fw = p;
                fh = p;
            end
            if (!ignore_blk && !square_pow2) begin
                if (fw % bw != 0) fw += bw - fw % bw;
                if (fh % bh != 0) fh += bh - fh % bh;
            end
            if (fw > tmse_pkg::FIT_MAX) fw = tmse_pkg::FIT_MAX;
            if (fh > tmse_pkg::FIT_MAX) fh = tmse_pkg::FIT_MAX;

            nbytes = 0;
            if (ok) begin
                blocks = ((w + bw - 1) / bw) * ((h + bh - 1) / bh);
                if (blocks > (64'd1 << 39)) begin
                    nbytes = tmse_pkg::BYTES_MAX;
                end else begin
                    nbytes = blocks * bits_per_blk / 8;
                    if (nbytes > tmse_pkg::BYTES_MAX) nbytes = tmse_pkg::BYTES_MAX;
                end
            end

            a.mips   = tmse_pkg::MIP_W'(mips);
            a.ok     = ok;
            a.fit_w  = tmse_pkg::FIT_W'(fw);
            a.fit_h  = tmse_pkg::FIT_W'(fh);
            a.nbytes = tmse_pkg::BYTES_W'(nbytes);
            return a;
        endfunction

        function void note_input(logic [tmse_pkg::DIM_BITS-1:0] w, h, d);
            pending_answers.push_back(predict_sizes(w, h, d));
        endfunction

        task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
            n_bad++;
            $display("mismatch after %0d results: %s got %0d expected %0d",
                     n_checked, what, got, want);
        endtask

        task check_result(logic [tmse_pkg::MIP_W-1:0] mips, logic ok,
                          logic [tmse_pkg::FIT_W-1:0] fw, logic [tmse_pkg::FIT_W-1:0] fh,
                          logic [tmse_pkg::BYTES_W-1:0] nbytes);
            t_size_answer want;
            if (pending_answers.size() == 0) begin
                flag_mismatch("unrequested word, mip_count", 64'(mips), 64'd0);
                return;
            end
            want = pending_answers.pop_front();
            n_checked++;
            if (mips !== want.mips)
                flag_mismatch("mip_count", 64'(mips), 64'(want.mips));
            if (ok !== want.ok)
                flag_mismatch("size_valid", 64'(ok), 64'(want.ok));
            if (fw !== want.fit_w)
                flag_mismatch("fit_width", 64'(fw), 64'(want.fit_w));
            if (fh !== want.fit_h)
                flag_mismatch("fit_height", 64'(fh), 64'(want.fit_h));
            if (nbytes !== want.nbytes)
                flag_mismatch("data_bytes", 64'(nbytes), 64'(want.nbytes));
        endtask

        task close_out();
            if (pending_answers.size() != 0)
                flag_mismatch("words never answered", 64'(pending_answers.size()), 64'd0);
        endtask
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic [tmse_pkg::DIM_BITS-1:0]      i_image_width;
    logic [tmse_pkg::DIM_BITS-1:0]      i_image_height;
    logic [tmse_pkg::DIM_BITS-1:0]      i_image_depth;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic [tmse_pkg::MIP_W-1:0]         o_mip_count;
    logic                               o_size_valid;
    logic [tmse_pkg::FIT_W-1:0]         o_fit_width;
    logic [tmse_pkg::FIT_W-1:0]         o_fit_height;
    logic [tmse_pkg::BYTES_W-1:0]       o_data_bytes;
    logic                               i_cfg_we;
    logic [3:0]                         i_cfg_index;
    logic [tmse_pkg::CFG_W-1:0]         i_cfg_data;

    t_mip_size_scoreboard sb;

    int unsigned burst_left   = 0;
    int unsigned n_sent       = 0;
    int unsigned n_formats    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_hold      = 0;
    int unsigned rx_span      = 0;
    t_rx_mode    rx_mode      = RX_OPEN;

    texture_mip_and_size_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_image_width  (i_image_width),
        .i_image_height (i_image_height),
        .i_image_depth  (i_image_depth),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mip_count    (o_mip_count),
        .o_size_valid   (o_size_valid),
        .o_fit_width    (o_fit_width),
        .o_fit_height   (o_fit_height),
        .o_data_bytes   (o_data_bytes),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: stall style changes every so often. Open = always ready,
    // coin = ready on a coin flip, long = mostly ready with stalls of random
    // length.
    always @(posedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_span <= $urandom_range(20, 200);
        end else begin
            rx_span <= rx_span - 1;
        end
        if (rx_hold != 0) begin
            i_out_ready <= 1'b0;
            rx_hold     <= rx_hold - 1;
        end else begin
            case (rx_mode)
                RX_OPEN: i_out_ready <= 1'b1;
                RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        i_out_ready <= 1'b0;
                        rx_hold     <= $urandom_range(1, 23);
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Output monitor: values read here are the ones from before the edge,
    // since every testbench drive is nonblocking.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            sb.check_result(o_mip_count, o_size_valid, o_fit_width, o_fit_height,
                            o_data_bytes);
    end

    // Watchdog: any word moving on either channel clears the count.
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word. Bursts of random length, random gaps between them.
    // Valid is only lowered at the start of a gap, so back-to-back words
    // never see valid dropped and raised in the same step.
    task automatic push_item(input logic [tmse_pkg::DIM_BITS-1:0] w, h, d);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_image_width  <= w;
        i_image_height <= h;
        i_image_depth  <= d;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_input(w, h, d);
        n_sent++;
    endtask

    // Drop valid, wait for every owed word, then sit out one full latency.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [3:0] idx,
                             input logic [tmse_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Write all eight registers. Unused upper data bits carry noise; a
    // write to an unmapped index goes last so any aliasing would show.
    task automatic set_format(input logic [15:0] mw, mh, input logic [3:0] bw, bh,
                              input logic [7:0] bpb, input logic comp, sq, ign);
        logic [tmse_pkg::CFG_W-1:0] noise;
        noise = tmse_pkg::CFG_W'($urandom);
        write_cfg(tmse_pkg::REG_MIN_WIDTH, mw);
        write_cfg(tmse_pkg::REG_MIN_HEIGHT, mh);
        write_cfg(tmse_pkg::REG_BLOCK_WIDTH, {noise[15:4], bw});
        write_cfg(tmse_pkg::REG_BLOCK_HEIGHT, {noise[11:0], bh});
        write_cfg(tmse_pkg::REG_BITS_PER_BLOCK, {noise[7:0], bpb});
        write_cfg(tmse_pkg::REG_IS_COMPRESSED, {noise[15:1], comp});
        write_cfg(tmse_pkg::REG_NEEDS_SQUARE, {noise[14:0], sq});
        write_cfg(tmse_pkg::REG_IGNORE_BLOCK, {noise[12:0], noise[2:1], ign});
        write_cfg(tmse_pkg::REG_IGNORE_BLOCK + 4'd1 + 4'($urandom_range(0, 7)), ~noise);
        i_cfg_we <= 1'b0;
        n_formats++;
    endtask

    function automatic logic [15:0] pick_min();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2, 3:    return 16'($urandom_range(1, 16));
            default: return 16'd1;
        endcase
    endfunction

    // Random format, biased toward small minimums so halving runs deep
    task automatic random_format();
        logic [3:0] bw, bh;
        logic [7:0] bpb;
        bw  = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'(1 << $urandom_range(0, 3));
        bh  = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'(1 << $urandom_range(0, 3));
        bpb = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'(8 << $urandom_range(0, 4));
        set_format(pick_min(), pick_min(), bw, bh, bpb, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Mostly block-aligned sizes with power-of-two factors (long halving
    // chains, legal sizes), plus squares, noise, tiny sizes and extremes.
    function automatic void pick_dims(output logic [tmse_pkg::DIM_BITS-1:0] w, h, d);
        longint unsigned bw, bh;
        int unsigned k;
        bw = (sb.blk_w == 0) ? 1 : sb.blk_w;
        bh = (sb.blk_h == 0) ? 1 : sb.blk_h;
        d  = tmse_pkg::DIM_BITS'($urandom >> $urandom_range(0, 31));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (sb.square_pow2) begin
                    k = $urandom_range(0, tmse_pkg::DIM_BITS - 1);
                    w = tmse_pkg::DIM_BITS'(64'd1 << k);
                    h = w;
                end else begin
                    w = tmse_pkg::DIM_BITS'(bw * $urandom_range(1, 3) << $urandom_range(0, 12));
                    h = tmse_pkg::DIM_BITS'(bh * $urandom_range(1, 3) << $urandom_range(0, 12));
                end
            end
            4, 5: begin
                k = $urandom_range(0, tmse_pkg::DIM_BITS - 1);
                w = tmse_pkg::DIM_BITS'((64'd1 << k) + $urandom_range(0, 1));
                h = ($urandom_range(0, 3) == 0) ? tmse_pkg::DIM_BITS'(64'd1 << k) : w;
            end
            6, 7: begin
                w = tmse_pkg::DIM_BITS'($urandom);
                h = tmse_pkg::DIM_BITS'($urandom);
            end
            8: begin
                w = tmse_pkg::DIM_BITS'($urandom_range(0, 20));
                h = tmse_pkg::DIM_BITS'($urandom_range(0, 20));
            end
            default: begin
                w = $urandom_range(0, 1) ? '1 : '0;
                h = $urandom_range(0, 1) ? '1 : tmse_pkg::DIM_BITS'($urandom);
                d = $urandom_range(0, 1) ? '1 : '0;
            end
        endcase
    endfunction

    initial begin
        logic [tmse_pkg::DIM_BITS-1:0] w, h, d;
        sb             = new();
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_image_width  = '0;
        i_image_height = '0;
        i_image_depth  = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = tmse_pkg::REG_MIN_WIDTH;
        i_cfg_data     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: field extremes, zero sides, deepest depth count
        n_formats = 1;
        push_item(16'd0, 16'd0, 16'd0);
        push_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_item(16'd1, 16'd1, 16'd1);
        push_item(16'd0, 16'd7, 16'd1);
        push_item(16'd40000, 16'd3, 16'hFFFF);
        push_item(16'd32768, 16'd1, 16'd2);

        // 4x4 compressed blocks, min 4: aligned, unaligned, below minimum
        settle();
        set_format(16'd4, 16'd4, 4'd4, 4'd4, 8'd64, 1'b1, 1'b0, 1'b0);
        push_item(16'd1024, 16'd512, 16'd1);
        push_item(16'd1023, 16'd1024, 16'd8);
        push_item(16'd2, 16'd2, 16'd0);
        push_item(16'd4, 16'd4, 16'd4);
        push_item(16'd12, 16'd20, 16'd0);

        // square power of two: zero side, non-square, rounding to 65536
        settle();
        set_format(16'd1, 16'd1, 4'd1, 4'd1, 8'd32, 1'b0, 1'b1, 1'b0);
        push_item(16'd256, 16'd256, 16'd1);
        push_item(16'd0, 16'd0, 16'd0);
        push_item(16'd255, 16'd255, 16'd9);
        push_item(16'd256, 16'd128, 16'd1);
        push_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_item(16'd3, 16'd5000, 16'd0);

        // largest minimums, large blocks, widest bits per block
        settle();
        set_format(16'hFFFF, 16'hFFFF, 4'd15, 4'd13, 8'd255, 1'b0, 1'b0, 1'b0);
        push_item(16'hFFFF, 16'hFFFF, 16'd0);
        push_item(16'hFFFE, 16'd1, 16'd1);
        push_item(16'd0, 16'd0, 16'hFFFF);

        // zero minimum, zero block and zero bits per block act as 1 / 1 / 0
        settle();
        set_format(16'd0, 16'd0, 4'd0, 4'd0, 8'd0, 1'b1, 1'b0, 1'b0);
        push_item(16'd5, 16'd7, 16'd3);
        push_item(16'd0, 16'd0, 16'd9);
        push_item(16'hFFFF, 16'd1, 16'd1);

        // byte count saturation, and just below it
        settle();
        set_format(16'd1, 16'd1, 4'd1, 4'd1, 8'd255, 1'b0, 1'b0, 1'b1);
        push_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_item(16'hFFFF, 16'd32768, 16'd0);

        // random formats, random words under each
        for (int f = 0; f < RANDOM_FORMATS; f++) begin
            settle();
            random_format();
            for (int n = 0; n < WORDS_PER_FORMAT; n++) begin
                pick_dims(w, h, d);
                push_item(w, h, d);
            end
        end

        settle();
        sb.close_out();
        $display("run covered %0d input words under %0d register settings", n_sent, n_formats);
        $display("%0d result words checked, %0d mismatches", sb.n_checked, sb.n_bad);
        if (sb.n_bad == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
